>>> hdl/ffha_pkg.sv
// Shared constants, types and codes for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

   localparam int HEAP_BYTES    = 4096;
   localparam int HEADER_BYTES  = 24;
   localparam int MAX_BLOCKS    = 128;
   localparam int GRANULE_BYTES = 16;

   localparam int SIZE_W = 12;
   localparam int IDX_W  = 7;
   localparam int CNT_W  = 8;
   localparam int POS_W  = 13;
   localparam int SUM_W  = 13;
   localparam int ENT_W  = SIZE_W + 1;

   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
   localparam logic [POS_W-1:0]  HDR      = POS_W'(HEADER_BYTES);
   localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(HEADER_BYTES + GRANULE_BYTES);
   localparam logic [POS_W-1:0]  GRAN_M1   = POS_W'(GRANULE_BYTES - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BLOCKS);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NULL    = 2'd1;
   localparam logic [1:0] ST_NOFIT   = 2'd2;
   localparam logic [1:0] ST_BADOFF  = 2'd3;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic init;
      logic load;
      logic issue;
      logic process;
      logic flush;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
   } stat_type;

endpackage

>>> hdl/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ffha_ctrl.sv
// Sequencer for the allocator: init, scan passes, flush and result.
// Depends on ffha_pkg.
module ffha_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::stat_type stat,
   output ffha_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RUN_A = 3'd2;
   localparam logic [2:0] S_RUN_B = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_RUN_A;
            end
         end
         S_RUN_A: begin
            cmd.issue = 1'b1;
            state_in  = stat.scan_end ? S_FLUSH : S_RUN_B;
         end
         S_RUN_B: begin
            cmd.process = 1'b1;
            state_in    = S_RUN_A;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_RUN_A)
      else $error("load did not start scan");
   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> cmd.finish)
      else $error("flush not followed by finish");
   a_proc_after_issue: assert property (@(posedge clock) disable iff (reset)
      cmd.process |-> $past(cmd.issue))
      else $error("process without issue");

endmodule

>>> hdl/ffha_dp.sv
// Datapath: ping-pong block tables, scan/rewrite pass with split and merge, totals.
// Depends on ffha_pkg and ffha_ram.
module ffha_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ffha_pkg::cmd_type             cmd,
   output ffha_pkg::stat_type            stat,
   input  logic                          req_action,
   input  logic [11:0]                   req_size,
   input  logic [11:0]                   req_data_offset,
   output logic                          rsp_valid,
   output logic [11:0]                   rsp_result_offset,
   output logic [1:0]                    rsp_status,
   output logic [12:0]                   rsp_free_bytes,
   output logic [12:0]                   rsp_used_bytes,
   output logic [12:0]                   rsp_total_bytes
);

   localparam int SW = ffha_pkg::SIZE_W;
   localparam int PW = ffha_pkg::POS_W;
   localparam int CW = ffha_pkg::CNT_W;
   localparam int UW = ffha_pkg::SUM_W;

   logic          sel_ff;
   logic [CW-1:0] count_ff, rd_idx_ff, wr_idx_ff;
   logic [PW-1:0] pos_ff;
   logic          pend_valid_ff, pend_free_ff;
   logic [SW-1:0] pend_size_ff;
   logic          extra_valid_ff;
   logic [SW-1:0] extra_size_ff;
   logic          taken_ff, found_ff, action_ff, noop_ff;
   logic [SW-1:0] off_ff, target_ff;
   logic [PW-1:0] rounded_ff;
   logic [UW-1:0] fsum_ff, usum_ff;
   logic          rsp_valid_ff;
   logic [11:0]   rsp_off_ff;
   logic [1:0]    rsp_status_ff;
   logic [UW-1:0] rsp_free_ff, rsp_used_ff;

   logic [ffha_pkg::ENT_W-1:0] rd0, rd1, rd_ent, wr_data;
   logic                       wr_en, wr_bank;
   logic [ffha_pkg::IDX_W-1:0] wr_addr;

   logic          e_free, ep_free, take, split, match, do_merge, wr_pend;
   logic [SW-1:0] e_size, ep_size, rest;
   logic [PW+1:0] needed;
   logic [1:0]    status;

   assign rd_ent = sel_ff ? rd1 : rd0;
   assign e_free = rd_ent[SW];
   assign e_size = rd_ent[SW-1:0];

   always_comb begin
      needed  = {2'b0, rounded_ff} + (PW+2)'(ffha_pkg::HEADER_BYTES);
      take    = !noop_ff && (action_ff == ffha_pkg::ACT_ALLOC) && !taken_ff && e_free &&
                ({{(PW+2-SW){1'b0}}, e_size} >= needed);
      rest    = e_size - needed[SW-1:0];
      split   = take && (rest > ffha_pkg::SPLIT_MIN) && (count_ff < ffha_pkg::CNT_MAX);
      match   = !noop_ff && (action_ff == ffha_pkg::ACT_FREE) && !found_ff &&
                (({1'b0, pos_ff} + {1'b0, ffha_pkg::HDR}) == {2'b0, target_ff});
      ep_free = take ? 1'b0 : (match ? 1'b1 : e_free);
      ep_size = split ? rounded_ff[SW-1:0] : e_size;
      do_merge = !split && pend_valid_ff && pend_free_ff && ep_free;
      wr_pend  = ((cmd.process && !do_merge) || cmd.flush) && pend_valid_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = {pend_free_ff, pend_size_ff};
      wr_bank = !sel_ff;
      wr_addr = wr_idx_ff[ffha_pkg::IDX_W-1:0];
      priority if (cmd.init) begin
         wr_en   = 1'b1;
         wr_bank = sel_ff;
         wr_addr = '0;
         wr_data = {1'b1, ffha_pkg::INIT_SIZE};
      end else if (cmd.issue) begin
         wr_en   = extra_valid_ff;
         wr_data = {1'b0, extra_size_ff};
      end else if (wr_pend) begin
         wr_en = 1'b1;
      end
   end

   ffha_ram #(.WIDTH(ffha_pkg::ENT_W), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_bank0 (
      .clock(clock), .wr_en(wr_en && !wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_idx_ff[ffha_pkg::IDX_W-1:0]), .rd_data(rd0));

   ffha_ram #(.WIDTH(ffha_pkg::ENT_W), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_bank1 (
      .clock(clock), .wr_en(wr_en && wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_idx_ff[ffha_pkg::IDX_W-1:0]), .rd_data(rd1));

   always_comb begin
      priority if (noop_ff) begin
         status = ffha_pkg::ST_NULL;
      end else if (action_ff == ffha_pkg::ACT_ALLOC) begin
         status = taken_ff ? ffha_pkg::ST_OK : ffha_pkg::ST_NOFIT;
      end else begin
         status = found_ff ? ffha_pkg::ST_OK : ffha_pkg::ST_BADOFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         count_ff     <= CW'(1);
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         taken_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff  <= 1'b0;
         extra_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.load) begin
            action_ff  <= req_action;
            rounded_ff <= ({1'b0, req_size} + ffha_pkg::GRAN_M1) & ~ffha_pkg::GRAN_M1;
            target_ff  <= req_data_offset;
            noop_ff    <= req_action ? (req_data_offset == '0) : (req_size == '0);
            rd_idx_ff  <= '0;
            wr_idx_ff  <= '0;
            pos_ff     <= '0;
            pend_valid_ff  <= 1'b0;
            extra_valid_ff <= 1'b0;
            taken_ff   <= 1'b0;
            found_ff   <= 1'b0;
            off_ff     <= '0;
            fsum_ff    <= '0;
            usum_ff    <= '0;
         end
         if (cmd.issue && extra_valid_ff) begin
            extra_valid_ff <= 1'b0;
            wr_idx_ff      <= wr_idx_ff + CW'(1);
            usum_ff        <= usum_ff + UW'(extra_size_ff);
         end
         if (wr_pend) begin
            wr_idx_ff <= wr_idx_ff + CW'(1);
            if (pend_free_ff) begin
               fsum_ff <= fsum_ff + UW'(pend_size_ff);
            end else begin
               usum_ff <= usum_ff + UW'(pend_size_ff);
            end
         end
         if (cmd.process) begin
            rd_idx_ff <= rd_idx_ff + CW'(1);
            pos_ff    <= pos_ff + ffha_pkg::HDR + PW'(e_size);
            taken_ff  <= taken_ff || take;
            found_ff  <= found_ff || match;
            if (take) begin
               off_ff <= SW'(pos_ff + ffha_pkg::HDR);
            end
            pend_valid_ff <= 1'b1;
            if (split) begin
               extra_valid_ff <= 1'b1;
               extra_size_ff  <= ep_size;
               pend_free_ff   <= 1'b1;
               pend_size_ff   <= rest;
            end else if (do_merge) begin
               pend_size_ff <= pend_size_ff + SW'(ffha_pkg::HEADER_BYTES) + ep_size;
            end else begin
               pend_free_ff <= ep_free;
               pend_size_ff <= ep_size;
            end
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.finish) begin
            sel_ff        <= !sel_ff;
            count_ff      <= wr_idx_ff;
            rsp_valid_ff  <= 1'b1;
            rsp_off_ff    <= off_ff;
            rsp_status_ff <= status;
            rsp_free_ff   <= fsum_ff;
            rsp_used_ff   <= usum_ff;
         end
      end
   end

   assign stat.scan_end     = (rd_idx_ff == count_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_offset = rsp_off_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_bytes    = rsp_free_ff;
   assign rsp_used_bytes    = rsp_used_ff;
   assign rsp_total_bytes   = rsp_free_ff + rsp_used_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= ffha_pkg::CNT_MAX)
      else $error("block count out of range");
   a_wr_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wr_idx_ff} <= {1'b0, rd_idx_ff} + (CW+1)'(1))
      else $error("write index ran ahead of read index");
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      !(taken_ff && found_ff))
      else $error("allocate and free hit in one transaction");

endmodule

>>> hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl, ffha_dp (and ffha_ram through ffha_dp).
//
//  channel   handshake         payload
//  request   start / busy      req_action, req_size, req_data_offset
//  response  rsp_valid strobe  rsp_result_offset, rsp_status, rsp_*_bytes
//
// Each transaction makes one pass over the block table, reading each entry from
// RAM (issue state) and then processing it, plus load, flush and result steps.
// After reset the S_INIT state seeds the table.
// Reset is synchronous. rsp_valid pulses one cycle; the receiver cannot stall.
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [11:0] req_size,
   input  logic [11:0] req_data_offset,
   output logic        rsp_valid,
   output logic [11:0] rsp_result_offset,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_free_bytes,
   output logic [12:0] rsp_used_bytes,
   output logic [12:0] rsp_total_bytes
);

   ffha_pkg::cmd_type  cmd;
   ffha_pkg::stat_type stat;

   ffha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd));

   ffha_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_action(req_action), .req_size(req_size), .req_data_offset(req_data_offset),
      .rsp_valid(rsp_valid), .rsp_result_offset(rsp_result_offset),
      .rsp_status(rsp_status), .rsp_free_bytes(rsp_free_bytes),
      .rsp_used_bytes(rsp_used_bytes), .rsp_total_bytes(rsp_total_bytes));

endmodule
